>>> rtl/indexed_min_heap_with_lookup_core_macros.svh
// Assertion macros shared by the heap core RTL.
`ifndef INDEXED_MIN_HEAP_WITH_LOOKUP_CORE_MACROS_SVH
`define INDEXED_MIN_HEAP_WITH_LOOKUP_CORE_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define IMH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks a property on every rising clock edge, including during reset.
`define IMH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/imh_pkg.sv
// ----------------------------------------------------------------------------
// imh_pkg
// Types, constants and helpers shared by the indexed min-heap core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package imh_pkg;

  // Heap capacity and the widths that follow from it.
  localparam int CAPACITY = 256;
  localparam int AW       = $clog2(CAPACITY);
  localparam int CW       = AW + 1;

  // Command codes on the command port.
  localparam logic [2:0] CMD_ADD     = 3'd0;
  localparam logic [2:0] CMD_SET     = 3'd1;
  localparam logic [2:0] CMD_DELETE  = 3'd2;
  localparam logic [2:0] CMD_SEARCH  = 3'd3;
  localparam logic [2:0] CMD_MIN     = 3'd4;
  localparam logic [2:0] CMD_MAX     = 3'd5;
  localparam logic [2:0] CMD_EXTRACT = 3'd6;

  // Status codes of a result.
  localparam logic [1:0] ST_SILENT   = 2'd0;
  localparam logic [1:0] ST_VALID    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_ERROR    = 2'd3;

  // Classified operation handed from the front end to the engine.
  typedef enum logic [2:0] {
    OP_ADD, OP_SET, OP_DELETE, OP_SEARCH, OP_MIN, OP_MAX, OP_EXTRACT, OP_BAD
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [63:0] key;
    logic [63:0] payload;
  } cmd_t;

  // One heap slot.
  typedef struct packed {
    logic [63:0] key;
    logic [63:0] data;
  } entry_t;

  // One result transaction.
  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] key;
    logic [7:0]  position;
    logic [63:0] data;
  } result_t;

  // Signed less-than on two's complement keys.
  function automatic logic key_less(input logic [63:0] a, input logic [63:0] b);
    return $signed(a) < $signed(b);
  endfunction

endpackage

>>> rtl/indexed_min_heap_with_lookup_core.sv
// ----------------------------------------------------------------------------
// indexed_min_heap_with_lookup_core
// Indexed binary min-heap of unique signed keys with data words.
// ----------------------------------------------------------------------------
// Each command yields one result. Add, set, delete and search first look the
// key up linearly through the single read port of the slot memory, at one
// entry per cycle, before any sift. A sift up moves parents down into the hole
// and a sift down moves the smaller child up. Min reads the root, max scans
// the leaf half and extract reads the root before a sift down. Two commands
// queue ahead of the engine and one result waits for pop.
`timescale 1ns / 1ps

module indexed_min_heap_with_lookup_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  command_i,
  input  logic [63:0] key_i,
  input  logic [63:0] payload_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status_o,
  output logic [63:0] result_key_o,
  output logic [7:0]  result_position_o,
  output logic [63:0] result_data_o
);

  imh_pkg::cmd_t    cmd;
  logic             cmd_valid, cmd_pop, res_valid;
  imh_pkg::result_t res;

  // Command intake and decode.
  imh_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .command_i   (command_i),
    .key_i       (key_i),
    .payload_i   (payload_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // Heap engine.
  imh_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_pop_i   (pop)
  );

  assign empty             = !res_valid;
  assign status_o          = res.status;
  assign result_key_o      = res.key;
  assign result_position_o = res.position;
  assign result_data_o     = res.data;

endmodule

>>> rtl/imh_front.sv
// ----------------------------------------------------------------------------
// imh_front
// Accepts command transactions, decodes them and holds them in a two-entry
// queue for the engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module imh_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  logic [2:0]         command_i,
  input  logic [63:0]        key_i,
  input  logic [63:0]        payload_i,
  output logic               cmd_valid_o,
  output imh_pkg::cmd_t      cmd_o,
  input  logic               cmd_pop_i
);

  imh_pkg::cmd_t slot_q [2];
  logic          wp_q, rp_q;
  logic [1:0]    fill_q;
  logic          do_push, do_pop;
  imh_pkg::cmd_t dec;

  // Decode the command code into an operation.
  always_comb begin
    dec.key     = key_i;
    dec.payload = payload_i;
    case (command_i)
      imh_pkg::CMD_ADD:     dec.op = imh_pkg::OP_ADD;
      imh_pkg::CMD_SET:     dec.op = imh_pkg::OP_SET;
      imh_pkg::CMD_DELETE:  dec.op = imh_pkg::OP_DELETE;
      imh_pkg::CMD_SEARCH:  dec.op = imh_pkg::OP_SEARCH;
      imh_pkg::CMD_MIN:     dec.op = imh_pkg::OP_MIN;
      imh_pkg::CMD_MAX:     dec.op = imh_pkg::OP_MAX;
      imh_pkg::CMD_EXTRACT: dec.op = imh_pkg::OP_EXTRACT;
      default:              dec.op = imh_pkg::OP_BAD;
    endcase
  end

  assign full_o      = fill_q[1];
  assign cmd_valid_o = (fill_q != 2'd0);
  assign cmd_o       = slot_q[rp_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  // Queue pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= 1'b0;
      rp_q   <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (do_push) wp_q <= ~wp_q;
      if (do_pop)  rp_q <= ~rp_q;
      fill_q <= fill_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wp_q] <= dec;
  end

endmodule

>>> rtl/imh_engine.sv
// ----------------------------------------------------------------------------
// imh_engine
// Carries out heap commands over a slot memory with one read and one write
// port and holds the result transaction until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "indexed_min_heap_with_lookup_core_macros.svh"

module imh_engine (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cmd_valid_i,
  input  imh_pkg::cmd_t          cmd_i,
  output logic                   cmd_pop_o,
  output logic                   res_valid_o,
  output imh_pkg::result_t       res_o,
  input  logic                   res_pop_i
);

  localparam int AW = imh_pkg::AW;
  localparam int CW = imh_pkg::CW;

  typedef enum logic [3:0] {
    S_IDLE, S_FIND, S_DLAST, S_UP, S_UPC, S_DN, S_DNL, S_DNR, S_DNC,
    S_ROOT, S_XLAST, S_MAX, S_OUT
  } state_e;

  state_e                state_q, state_d;
  logic [CW-1:0]         cnt_q, cnt_d, idx_q, idx_d;
  logic                  rv_q, rv_d, moved_q, moved_d, have_q, have_d;
  logic [AW-1:0]         rtag_q, rtag_d, p_q, p_d, bi_q, bi_d;
  imh_pkg::op_e          op_q, op_d;
  logic [63:0]           key_q, key_d, pay_q, pay_d;
  imh_pkg::entry_t       e_q, e_d, b_q, b_d, rd_q;
  imh_pkg::result_t      res_q, res_d, out_q;
  logic                  ov_q;
  logic                  out_load;

  // Memory port controls.
  logic [AW-1:0]         ra, wa;
  logic                  we;
  imh_pkg::entry_t       wd;
  imh_pkg::entry_t       mem [imh_pkg::CAPACITY];

  logic [CW-1:0]         left, nxt;
  logic [AW-1:0]         parent;
  logic                  hit;

  assign left   = {p_q, 1'b1};
  assign nxt    = cnt_q - CW'(1);
  assign parent = AW'((p_q - AW'(1)) >> 1);
  assign hit    = rv_q && (rd_q.key == key_q);

  assign res_valid_o = ov_q;
  assign res_o       = out_q;

  // Command sequencer.
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    rv_d      = 1'b0;
    rtag_d    = rtag_q;
    p_d       = p_q;
    bi_d      = bi_q;
    moved_d   = moved_q;
    have_d    = have_q;
    op_d      = op_q;
    key_d     = key_q;
    pay_d     = pay_q;
    e_d       = e_q;
    b_d       = b_q;
    res_d     = res_q;
    ra        = '0;
    we        = 1'b0;
    wa        = p_q;
    wd        = e_q;
    cmd_pop_o = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          op_d      = cmd_i.op;
          key_d     = cmd_i.key;
          pay_d     = cmd_i.payload;
          res_d     = '{status: imh_pkg::ST_ERROR, key: '0, position: '0, data: '0};
          idx_d     = '0;
          have_d    = 1'b0;
          case (cmd_i.op)
            imh_pkg::OP_ADD, imh_pkg::OP_SET, imh_pkg::OP_DELETE,
            imh_pkg::OP_SEARCH: state_d = S_FIND;
            imh_pkg::OP_MIN, imh_pkg::OP_EXTRACT:
              state_d = (cnt_q == '0) ? S_OUT : S_ROOT;
            imh_pkg::OP_MAX: begin
              idx_d   = cnt_q >> 1;
              state_d = (cnt_q == '0) ? S_OUT : S_MAX;
            end
            default: state_d = S_OUT;
          endcase
        end
      end

      // Linear lookup, one read issued per cycle.
      S_FIND: begin
        if (idx_q < cnt_q) begin
          ra     = idx_q[AW-1:0];
          rv_d   = 1'b1;
          rtag_d = idx_q[AW-1:0];
          idx_d  = idx_q + CW'(1);
        end
        if (hit) begin
          rv_d = 1'b0;
          case (op_q)
            imh_pkg::OP_SET: begin
              we      = 1'b1;
              wa      = rtag_q;
              wd      = '{key: key_q, data: pay_q};
              res_d   = '0;
              state_d = S_OUT;
            end
            imh_pkg::OP_DELETE: begin
              cnt_d   = nxt;
              res_d   = '0;
              p_d     = rtag_q;
              moved_d = 1'b0;
              ra      = nxt[AW-1:0];
              state_d = ({1'b0, rtag_q} == nxt) ? S_OUT : S_DLAST;
            end
            imh_pkg::OP_SEARCH: begin
              res_d   = '{status: imh_pkg::ST_VALID, key: key_q,
                          position: 8'(rtag_q), data: rd_q.data};
              state_d = S_OUT;
            end
            default: state_d = S_OUT;
          endcase
        end else if (!rv_q && idx_q >= cnt_q) begin
          rv_d = 1'b0;
          case (op_q)
            imh_pkg::OP_ADD: begin
              if (cnt_q < CW'(imh_pkg::CAPACITY)) begin
                e_d     = '{key: key_q, data: pay_q};
                p_d     = cnt_q[AW-1:0];
                cnt_d   = cnt_q + CW'(1);
                moved_d = 1'b0;
                res_d   = '0;
                state_d = S_UP;
              end else begin
                state_d = S_OUT;
              end
            end
            imh_pkg::OP_SEARCH: begin
              res_d   = '{status: imh_pkg::ST_NOTFOUND, key: '0, position: '0, data: '0};
              state_d = S_OUT;
            end
            default: state_d = S_OUT;
          endcase
        end
      end

      S_DLAST: begin
        e_d     = rd_q;
        state_d = S_UP;
      end

      // Sift up: move parents down into the hole.
      S_UP: begin
        if (p_q == '0) begin
          if (moved_q) begin
            we      = 1'b1;
            state_d = S_OUT;
          end else begin
            state_d = S_DN;
          end
        end else begin
          ra      = parent;
          state_d = S_UPC;
        end
      end

      S_UPC: begin
        if (imh_pkg::key_less(e_q.key, rd_q.key)) begin
          we      = 1'b1;
          wd      = rd_q;
          p_d     = parent;
          moved_d = 1'b1;
          state_d = S_UP;
        end else if (moved_q) begin
          we      = 1'b1;
          state_d = S_OUT;
        end else begin
          state_d = S_DN;
        end
      end

      // Sift down: move the smaller child up into the hole.
      S_DN: begin
        if (left >= cnt_q) begin
          we      = 1'b1;
          state_d = S_OUT;
        end else begin
          ra      = left[AW-1:0];
          state_d = S_DNL;
        end
      end

      S_DNL: begin
        b_d  = rd_q;
        bi_d = left[AW-1:0];
        if (CW'(left + CW'(1)) < cnt_q) begin
          ra      = AW'(left + CW'(1));
          state_d = S_DNR;
        end else begin
          state_d = S_DNC;
        end
      end

      S_DNR: begin
        if (imh_pkg::key_less(rd_q.key, b_q.key)) begin
          b_d  = rd_q;
          bi_d = AW'(left + CW'(1));
        end
        state_d = S_DNC;
      end

      S_DNC: begin
        we = 1'b1;
        if (imh_pkg::key_less(e_q.key, b_q.key)) begin
          state_d = S_OUT;
        end else begin
          wd      = b_q;
          p_d     = bi_q;
          state_d = S_DN;
        end
      end

      // Root read for min and extract.
      S_ROOT: begin
        res_d = '{status: imh_pkg::ST_VALID, key: rd_q.key, position: '0, data: rd_q.data};
        if (op_q == imh_pkg::OP_EXTRACT) begin
          cnt_d   = nxt;
          ra      = nxt[AW-1:0];
          state_d = (nxt == '0) ? S_OUT : S_XLAST;
        end else begin
          state_d = S_OUT;
        end
      end

      S_XLAST: begin
        e_d     = rd_q;
        p_d     = '0;
        state_d = S_DN;
      end

      // Scan of the leaf half for the largest key.
      S_MAX: begin
        if (idx_q < cnt_q) begin
          ra     = idx_q[AW-1:0];
          rv_d   = 1'b1;
          rtag_d = idx_q[AW-1:0];
          idx_d  = idx_q + CW'(1);
        end
        if (rv_q && (!have_q || imh_pkg::key_less(b_q.key, rd_q.key))) begin
          b_d    = rd_q;
          bi_d   = rtag_q;
          have_d = 1'b1;
        end
        if (!rv_q && idx_q >= cnt_q) begin
          res_d   = '{status: imh_pkg::ST_VALID, key: b_q.key,
                      position: 8'(bi_q), data: b_q.data};
          state_d = S_OUT;
        end
      end

      S_OUT: begin
        if (!ov_q || res_pop_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer state, entry count and the result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      rv_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rv_q    <= rv_d;
      if (out_load)       ov_q <= 1'b1;
      else if (res_pop_i) ov_q <= 1'b0;
    end
  end

  // Working registers without reset.
  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    rtag_q  <= rtag_d;
    p_q     <= p_d;
    bi_q    <= bi_d;
    moved_q <= moved_d;
    have_q  <= have_d;
    op_q    <= op_d;
    key_q   <= key_d;
    pay_q   <= pay_d;
    e_q     <= e_d;
    b_q     <= b_d;
    res_q   <= res_d;
    if (out_load) out_q <= res_q;
  end

  // Slot memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[ra];
  end

  `IMH_ASSERT(a_cnt_bound, cnt_q <= CW'(imh_pkg::CAPACITY), "entry count above capacity")
  `IMH_ASSERT(a_cnt_step, (cnt_q != $past(cnt_q)) |-> ((cnt_q == CW'($past(cnt_q) + CW'(1))) || (CW'(cnt_q + CW'(1)) == $past(cnt_q))), "entry count moved by more than one")
  `IMH_ASSERT(a_sift_pos, (state_q == S_DN) |-> ({1'b0, p_q} < cnt_q), "sift position outside the heap")
  `IMH_ASSERT(a_out_free, out_load |-> (!ov_q || res_pop_i), "result overwritten before it was taken")

endmodule

>>> tb/tb_indexed_min_heap_with_lookup_core.sv
// ----------------------------------------------------------------------------
// tb_indexed_min_heap_with_lookup_core
// Self-checking testbench for the indexed min-heap core.
// ----------------------------------------------------------------------------
// A directed table covers the empty heap, the key and data extremes, duplicate
// and missing keys and the unknown command. A fill pass drives the heap to its
// capacity, tries one more add, and drains it again by extract. Random
// commands over small key pools follow in four phases of sender idling and
// receiver stalling. Results are checked with the table or a heap model here.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_indexed_min_heap_with_lookup_core;

  localparam logic [2:0]  CMD_BAD  = 3'd7;
  localparam logic [63:0] KEY_LOW  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] KEY_HIGH = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int          POOL_N   = 32;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [2:0]  command_i = imh_pkg::CMD_MIN;
  logic [63:0] key_i = '0;
  logic [63:0] payload_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  status_o;
  logic [63:0] result_key_o;
  logic [7:0]  result_position_o;
  logic [63:0] result_data_o;

  // Model of the heap contents.
  logic [63:0] heap_key_m [imh_pkg::CAPACITY];
  logic [63:0] heap_data_m [imh_pkg::CAPACITY];
  int          heap_count_m = 0;

  imh_pkg::result_t pending_q[$];
  int          err_count = 0;
  int          sent_count = 0;
  int          checked_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic [63:0] key_pool [POOL_N];

  // Directed stimulus table.
  typedef struct {
    logic [2:0]       cmd;
    logic [63:0]      key;
    logic [63:0]      payload;
    bit               typed;
    imh_pkg::result_t res;
  } dir_row_t;

  dir_row_t dir_rows [23];

  indexed_min_heap_with_lookup_core i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .command_i         (command_i),
    .key_i             (key_i),
    .payload_i         (payload_i),
    .empty             (empty),
    .pop               (pop),
    .status_o          (status_o),
    .result_key_o      (result_key_o),
    .result_position_o (result_position_o),
    .result_data_o     (result_data_o)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Heap model helpers.
  function automatic void slot_swap(int a, int b);
    logic [63:0] k;
    logic [63:0] d;
    k = heap_key_m[a];
    d = heap_data_m[a];
    heap_key_m[a] = heap_key_m[b];
    heap_data_m[a] = heap_data_m[b];
    heap_key_m[b] = k;
    heap_data_m[b] = d;
  endfunction

  function automatic void bubble_up(int pos);
    int up;
    while (pos > 0) begin
      up = (pos - 1) / 2;
      if (!($signed(heap_key_m[pos]) < $signed(heap_key_m[up]))) break;
      slot_swap(pos, up);
      pos = up;
    end
  endfunction

  function automatic void bubble_down(int pos);
    int left;
    int best;
    forever begin
      left = 2 * pos + 1;
      if (left >= heap_count_m) break;
      best = left;
      if (left + 1 < heap_count_m &&
          $signed(heap_key_m[left + 1]) < $signed(heap_key_m[left])) best = left + 1;
      if ($signed(heap_key_m[pos]) < $signed(heap_key_m[best])) break;
      slot_swap(pos, best);
      pos = best;
    end
  endfunction

  function automatic int key_slot(logic [63:0] key);
    for (int i = 0; i < heap_count_m; i++) if (heap_key_m[i] == key) return i;
    return heap_count_m;
  endfunction

  // Applies one command to the heap model and returns its result.
  function automatic imh_pkg::result_t heap_apply(logic [2:0] cmd, logic [63:0] key,
                                                  logic [63:0] payload);
    imh_pkg::result_t r;
    int               pos;
    r = '{status: imh_pkg::ST_ERROR, key: '0, position: '0, data: '0};
    case (cmd)
      imh_pkg::CMD_ADD: begin
        if (key_slot(key) == heap_count_m && heap_count_m < imh_pkg::CAPACITY) begin
          heap_key_m[heap_count_m] = key;
          heap_data_m[heap_count_m] = payload;
          heap_count_m++;
          bubble_up(heap_count_m - 1);
          r.status = imh_pkg::ST_SILENT;
        end
      end
      imh_pkg::CMD_SET: begin
        pos = key_slot(key);
        if (pos != heap_count_m) begin
          heap_data_m[pos] = payload;
          r.status = imh_pkg::ST_SILENT;
        end
      end
      imh_pkg::CMD_DELETE: begin
        pos = key_slot(key);
        if (pos != heap_count_m) begin
          heap_count_m--;
          heap_key_m[pos] = heap_key_m[heap_count_m];
          heap_data_m[pos] = heap_data_m[heap_count_m];
          if (pos < heap_count_m) begin
            if (pos > 0 && $signed(heap_key_m[pos]) < $signed(heap_key_m[(pos - 1) / 2]))
              bubble_up(pos);
            else
              bubble_down(pos);
          end
          r.status = imh_pkg::ST_SILENT;
        end
      end
      imh_pkg::CMD_SEARCH: begin
        pos = key_slot(key);
        if (pos == heap_count_m) r.status = imh_pkg::ST_NOTFOUND;
        else r = '{status: imh_pkg::ST_VALID, key: key, position: pos[7:0],
                   data: heap_data_m[pos]};
      end
      imh_pkg::CMD_MIN: begin
        if (heap_count_m > 0)
          r = '{status: imh_pkg::ST_VALID, key: heap_key_m[0], position: '0,
                data: heap_data_m[0]};
      end
      imh_pkg::CMD_MAX: begin
        if (heap_count_m > 0) begin
          pos = heap_count_m / 2;
          for (int i = heap_count_m / 2; i < heap_count_m; i++)
            if ($signed(heap_key_m[pos]) < $signed(heap_key_m[i])) pos = i;
          r = '{status: imh_pkg::ST_VALID, key: heap_key_m[pos], position: pos[7:0],
                data: heap_data_m[pos]};
        end
      end
      imh_pkg::CMD_EXTRACT: begin
        if (heap_count_m > 0) begin
          r = '{status: imh_pkg::ST_VALID, key: heap_key_m[0], position: '0,
                data: heap_data_m[0]};
          heap_count_m--;
          heap_key_m[0] = heap_key_m[heap_count_m];
          heap_data_m[0] = heap_data_m[heap_count_m];
          bubble_down(0);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Drives one command transaction after a random gap and waits for it to be taken.
  task automatic send_cmd(logic [2:0] cmd, logic [63:0] key, logic [63:0] payload,
                          bit typed = 1'b0, imh_pkg::result_t typed_res = '0);
    imh_pkg::result_t r;
    int               gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct && gap < 20) gap++;
    if (gap > 0) begin
      @(negedge clk_i) push = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    push = 1'b1;
    command_i = cmd;
    key_i = key;
    payload_i = payload;
    do @(posedge clk_i); while (full);
    r = heap_apply(cmd, key, payload);
    pending_q.insert(pending_q.size(), typed ? typed_res : r);
    sent_count++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i) push = 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $time, field, got, want);
    err_count++;
  endtask

  // Receiver stalls are chosen at the falling edge.
  always @(negedge clk_i) pop = rst_ni && ($urandom_range(0, 99) >= recv_stall_pct);

  // Result checker.
  always @(posedge clk_i) begin
    imh_pkg::result_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_q.size() == 0) begin
        $display("[%0t] result transaction with nothing expected", $time);
        err_count++;
      end else begin
        want = pending_q.pop_front();
        checked_count++;
        if (status_o !== want.status) report_mismatch("status", status_o, want.status);
        if (result_key_o !== want.key) report_mismatch("key", result_key_o, want.key);
        if (result_position_o !== want.position)
          report_mismatch("position", result_position_o, want.position);
        if (result_data_o !== want.data) report_mismatch("data", result_data_o, want.data);
      end
    end
  end

  // Picks a random command over the current key pool.
  task automatic send_random();
    int          sel;
    logic [2:0]  cmd;
    logic [63:0] key;
    sel = $urandom_range(0, 99);
    if (sel < 30) cmd = imh_pkg::CMD_ADD;
    else if (sel < 40) cmd = imh_pkg::CMD_SET;
    else if (sel < 55) cmd = imh_pkg::CMD_DELETE;
    else if (sel < 70) cmd = imh_pkg::CMD_SEARCH;
    else if (sel < 78) cmd = imh_pkg::CMD_MIN;
    else if (sel < 86) cmd = imh_pkg::CMD_MAX;
    else if (sel < 97) cmd = imh_pkg::CMD_EXTRACT;
    else cmd = CMD_BAD;
    sel = $urandom_range(0, 99);
    if (sel < 88) key = key_pool[$urandom_range(0, POOL_N - 1)];
    else if (sel < 91) key = KEY_LOW;
    else if (sel < 94) key = KEY_HIGH;
    else key = {$urandom, $urandom};
    send_cmd(cmd, key, {$urandom, $urandom});
  endtask

  // Main stimulus.
  initial begin
    imh_pkg::result_t err_res;
    imh_pkg::result_t none_res;
    imh_pkg::result_t silent_res;
    err_res = '{status: imh_pkg::ST_ERROR, key: '0, position: '0, data: '0};
    none_res = '{status: imh_pkg::ST_NOTFOUND, key: '0, position: '0, data: '0};
    silent_res = '{status: imh_pkg::ST_SILENT, key: '0, position: '0, data: '0};

    dir_rows[0]  = '{imh_pkg::CMD_MIN,     '0, '0, 1'b1, err_res};
    dir_rows[1]  = '{imh_pkg::CMD_MAX,     '0, '0, 1'b1, err_res};
    dir_rows[2]  = '{imh_pkg::CMD_EXTRACT, '0, '0, 1'b1, err_res};
    dir_rows[3]  = '{imh_pkg::CMD_SEARCH,  64'd5, '0, 1'b1, none_res};
    dir_rows[4]  = '{imh_pkg::CMD_SET,     64'd5, '1, 1'b1, err_res};
    dir_rows[5]  = '{imh_pkg::CMD_DELETE,  64'd5, '0, 1'b1, err_res};
    dir_rows[6]  = '{CMD_BAD,              KEY_HIGH, '1, 1'b1, err_res};
    dir_rows[7]  = '{imh_pkg::CMD_ADD,     KEY_LOW, '1, 1'b1, silent_res};
    dir_rows[8]  = '{imh_pkg::CMD_ADD,     KEY_HIGH, '0, 1'b1, silent_res};
    dir_rows[9]  = '{imh_pkg::CMD_ADD,     KEY_LOW, 64'd9, 1'b1, err_res};
    dir_rows[10] = '{imh_pkg::CMD_ADD,     '0, 64'd1234, 1'b0, '0};
    dir_rows[11] = '{imh_pkg::CMD_ADD,     '1, 64'd55, 1'b0, '0};
    dir_rows[12] = '{imh_pkg::CMD_MIN,     '0, '0, 1'b1,
                     '{status: imh_pkg::ST_VALID, key: KEY_LOW, position: '0, data: '1}};
    dir_rows[13] = '{imh_pkg::CMD_MAX,     '0, '0, 1'b0, '0};
    dir_rows[14] = '{imh_pkg::CMD_SEARCH,  KEY_HIGH, '0, 1'b0, '0};
    dir_rows[15] = '{imh_pkg::CMD_SET,     '0, 64'hA5A5_5A5A_F0F0_0F0F, 1'b0, '0};
    dir_rows[16] = '{imh_pkg::CMD_SEARCH,  '0, '0, 1'b0, '0};
    dir_rows[17] = '{imh_pkg::CMD_DELETE,  KEY_LOW, '0, 1'b0, '0};
    dir_rows[18] = '{imh_pkg::CMD_MIN,     '0, '0, 1'b0, '0};
    dir_rows[19] = '{imh_pkg::CMD_EXTRACT, '0, '0, 1'b0, '0};
    dir_rows[20] = '{imh_pkg::CMD_EXTRACT, '0, '0, 1'b0, '0};
    dir_rows[21] = '{imh_pkg::CMD_EXTRACT, '0, '0, 1'b0, '0};
    dir_rows[22] = '{imh_pkg::CMD_EXTRACT, '0, '0, 1'b1, err_res};

    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    foreach (dir_rows[i])
      send_cmd(dir_rows[i].cmd, dir_rows[i].key, dir_rows[i].payload,
               dir_rows[i].typed, dir_rows[i].res);
    wait_drained();

    // Fill to capacity, overflow once, then drain by extract.
    for (int i = 0; i < imh_pkg::CAPACITY; i++)
      send_cmd(imh_pkg::CMD_ADD, {$urandom, $urandom}, {$urandom, $urandom});
    send_cmd(imh_pkg::CMD_ADD, {$urandom, $urandom}, '0);
    send_cmd(imh_pkg::CMD_MAX, '0, '0);
    send_cmd(imh_pkg::CMD_SEARCH, heap_key_m[imh_pkg::CAPACITY - 1], '0);
    while (heap_count_m > 0) send_cmd(imh_pkg::CMD_EXTRACT, '0, '0);
    wait_drained();

    // Random phases: no idling, sender idle, receiver stalls, both.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      foreach (key_pool[k]) key_pool[k] = {$urandom, $urandom};
      repeat (280) send_random();
      wait_drained();
    end

    repeat (300) @(posedge clk_i);
    $display("Ran %0d command transactions and checked %0d results,", sent_count,
             checked_count);
    $display("including a full heap and four idling phases; %0d mismatches.", err_count);
    if (err_count == 0 && pending_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #100_000_000;
    $display("Timeout with %0d results outstanding.", pending_q.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
